// ===== hw/rtl/fcl_pkg.sv =====
`timescale 1ns / 1ps

package fcl_pkg;

  localparam int PLANE_REGS       = 6;
  localparam int A_W              = 21;
  localparam int SQ_W             = 41;
  localparam int D2_W             = 42;
  localparam int LSQ_W            = 34;
  localparam int MODE_DIST_BIT    = 48;
  localparam int MODE_FRUSTUM_BIT = 49;
  localparam logic [A_W-1:0] DIFF_CLAMP = A_W'(1) << 20;

  typedef enum logic [2:0] {
    REG_PLANE_LEFT   = 3'd0,
    REG_PLANE_RIGHT  = 3'd1,
    REG_PLANE_BOTTOM = 3'd2,
    REG_PLANE_TOP    = 3'd3,
    REG_PLANE_NEAR   = 3'd4,
    REG_PLANE_FAR    = 3'd5,
    REG_CAMERA       = 3'd6,
    REG_LOD_MODES    = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CULL_VISIBLE  = 2'd0,
    CULL_DISTANCE = 2'd1,
    CULL_FRUSTUM  = 2'd2
  } cull_e;

  typedef struct packed {
    logic [15:0] tag;
    logic [1:0]  lod;
    logic        dist_cull;
    logic        check_frustum;
    logic        in_frustum;
  } ctl_t;

endpackage

// ===== hw/rtl/fcl_front.sv =====
`timescale 1ns / 1ps

module fcl_front import fcl_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          tag,
  input  logic [2:0][15:0]     box_min,
  input  logic [2:0][15:0]     box_max,
  input  logic [15:0]          far_limit,
  input  logic [15:0]          near_limit,
  input  logic                 always_visible,
  input  logic [47:0]          cam,
  input  logic [49:0]          lod_modes,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ctl_t                 ctl,
  output logic [2:0][CW-1:0]   lo,
  output logic [2:0][CW-1:0]   hi
);

  localparam int LW = (CW < 16) ? CW : 16;
  localparam int DW = CW + 2;
  localparam int MW = (DW > A_W) ? DW : A_W + 1;

  logic signed [CW-1:0] lo_c [3];
  logic signed [CW-1:0] hi_c [3];
  logic signed [CW-1:0] cam_c [3];
  logic signed [DW-1:0] diff [3];
  logic [MW-1:0]        mag [3];
  logic [A_W-1:0]       a_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo_c[k]  = $signed(CW'(box_min[k][LW-1:0]));
      hi_c[k]  = $signed(CW'(box_max[k][LW-1:0]));
      cam_c[k] = $signed(CW'(cam[16*k +: LW]));
      diff[k]  = DW'(lo_c[k]) + DW'(hi_c[k]) - (DW'(cam_c[k]) <<< 1);
      mag[k]   = diff[k][DW-1] ? MW'(-diff[k]) : MW'(diff[k]);
      a_c[k]   = (mag[k] > MW'(DIFF_CLAMP)) ? DIFF_CLAMP : mag[k][A_W-1:0];
    end
  end

  // threshold squares times four, follow the config register
  logic [LSQ_W-1:0] thr_sq [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      thr_sq[k] <= (LSQ_W'(lod_modes[16*k +: 16]) * LSQ_W'(lod_modes[16*k +: 16])) << 2;
    end
  end

  logic en1, en2, en3, en4;
  logic v1, v2, v3;

  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  // stage 1: clamped center offsets
  logic [15:0]        tag1, far1, near1;
  logic               av1;
  logic [2:0][CW-1:0] lo1, hi1;
  logic [A_W-1:0]     a1 [3];

  always_ff @(posedge clk) begin
    if (en1) begin
      tag1  <= tag;
      av1   <= always_visible;
      far1  <= far_limit;
      near1 <= near_limit;
      for (int k = 0; k < 3; k++) begin
        lo1[k] <= lo_c[k];
        hi1[k] <= hi_c[k];
        a1[k]  <= a_c[k];
      end
    end
  end

  // stage 2: squares
  logic [15:0]        tag2;
  logic               av2, far_nz2;
  logic [2:0][CW-1:0] lo2, hi2;
  logic [SQ_W-1:0]    sq2 [3];
  logic [31:0]        fsq2, nsq2;

  always_ff @(posedge clk) begin
    if (en2) begin
      tag2    <= tag1;
      av2     <= av1;
      lo2     <= lo1;
      hi2     <= hi1;
      far_nz2 <= (far1 != 16'd0);
      fsq2    <= 32'(far1) * 32'(far1);
      nsq2    <= 32'(near1) * 32'(near1);
      for (int k = 0; k < 3; k++) begin
        sq2[k] <= SQ_W'(a1[k]) * SQ_W'(a1[k]);
      end
    end
  end

  // stage 3: squared doubled distance
  logic [15:0]        tag3;
  logic               av3, far_nz3;
  logic [2:0][CW-1:0] lo3, hi3;
  logic [D2_W-1:0]    d2_3;
  logic [31:0]        fsq3, nsq3;

  always_ff @(posedge clk) begin
    if (en3) begin
      tag3    <= tag2;
      av3     <= av2;
      lo3     <= lo2;
      hi3     <= hi2;
      far_nz3 <= far_nz2;
      fsq3    <= fsq2;
      nsq3    <= nsq2;
      d2_3    <= D2_W'(sq2[0]) + D2_W'(sq2[1]) + D2_W'(sq2[2]);
    end
  end

  // stage 4: range check and level of detail
  logic [D2_W-1:0] far_lim, near_lim;
  logic            dist_hit;
  logic [1:0]      lod_c;

  always_comb begin
    far_lim  = D2_W'({fsq3, 2'b00});
    near_lim = D2_W'({nsq3, 2'b00});
    dist_hit = !av3 && lod_modes[MODE_DIST_BIT] && far_nz3 &&
               (d2_3 > far_lim || d2_3 < near_lim);
    priority if (d2_3 >= D2_W'(thr_sq[2])) lod_c = 2'd3;
    else if (d2_3 >= D2_W'(thr_sq[1]))     lod_c = 2'd2;
    else if (d2_3 >= D2_W'(thr_sq[0]))     lod_c = 2'd1;
    else                                   lod_c = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      ctl.tag           <= tag3;
      ctl.lod           <= lod_c;
      ctl.dist_cull     <= dist_hit;
      ctl.check_frustum <= !av3 && lod_modes[MODE_FRUSTUM_BIT];
      ctl.in_frustum    <= 1'b1;
      lo                <= lo3;
      hi                <= hi3;
    end
  end

endmodule

// ===== hw/rtl/fcl_plane_cell.sv =====
`timescale 1ns / 1ps

module fcl_plane_cell import fcl_pkg::*; #(
  parameter int CW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ctl_t               in_ctl,
  input  logic [2:0][CW-1:0] in_lo,
  input  logic [2:0][CW-1:0] in_hi,
  input  logic [63:0]        plane,
  output logic               out_valid,
  input  logic               out_ready,
  output ctl_t               out_ctl,
  output logic [2:0][CW-1:0] out_lo,
  output logic [2:0][CW-1:0] out_hi
);

  localparam int PW = CW + 16;
  localparam int SW = ((PW > 30) ? PW : 30) + 2;

  logic signed [15:0]   n [3];
  logic signed [CW-1:0] sel [3];
  logic signed [PW-1:0] prod_c [3];
  logic signed [15:0]   dd;

  // positive vertex: max where the normal is non-negative
  always_comb begin
    dd = $signed(plane[63:48]);
    for (int k = 0; k < 3; k++) begin
      n[k]      = $signed(plane[16*k +: 16]);
      sel[k]    = n[k][15] ? $signed(in_lo[k]) : $signed(in_hi[k]);
      prod_c[k] = PW'(n[k]) * PW'(sel[k]);
    end
  end

  logic va, ena, enb;

  assign enb      = !out_valid || out_ready;
  assign ena      = !va || enb;
  assign in_ready = ena;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ena) va <= in_valid;
      if (enb) out_valid <= va;
    end
  end

  ctl_t                 ctla;
  logic [2:0][CW-1:0]   loa, hia;
  logic signed [PW-1:0] proda [3];

  always_ff @(posedge clk) begin
    if (ena) begin
      ctla <= in_ctl;
      loa  <= in_lo;
      hia  <= in_hi;
      for (int k = 0; k < 3; k++) begin
        proda[k] <= prod_c[k];
      end
    end
  end

  logic signed [SW-1:0] acc;
  ctl_t                 ctl_next;

  assign acc = (SW'(dd) <<< 14) + SW'(proda[0]) + SW'(proda[1]) + SW'(proda[2]);

  always_comb begin
    ctl_next            = ctla;
    ctl_next.in_frustum = ctla.in_frustum && !acc[SW-1];
  end

  always_ff @(posedge clk) begin
    if (enb) begin
      out_ctl <= ctl_next;
      out_lo  <= loa;
      out_hi  <= hia;
    end
  end

endmodule

// ===== hw/rtl/frustum_distance_cull_lod.sv =====
// Culls one object per clock and picks its level of detail. An object enters as a box,
// an optional draw range and an always-visible flag; it leaves with its tag, a cull
// code and a level from 0 to 3. Front stages compute the squared center distance to the
// camera, its range check and the level; then a row of PLANE_COUNT cells, each with a
// product and an output register, tests the box's positive vertex against one frustum
// plane per cell, and an output register follows. A new request is taken every cycle
// while the output is drained; empty stages close up under backpressure. The user must
// write registers through the cfg port only while no objects are in flight; the block
// does not enforce this. Registers take effect for the next request.
`timescale 1ns / 1ps

module frustum_distance_cull_lod import fcl_pkg::*; #(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // object_tag, min_x, min_y, min_z, max_x, max_y, max_z, far_limit, near_limit
  input  logic [143:0]  s_tdata,
  // always_visible
  input  logic          s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // result_tag, cull_code, detail_level, zero fill
  output logic [23:0]   m_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  logic [63:0] planes [PLANE_REGS];
  logic [47:0] cam;
  logic [49:0] lod_modes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PLANE_REGS; i++) planes[i] <= '0;
      cam       <= '0;
      lod_modes <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_CAMERA:    cam <= cfg_data[47:0];
        REG_LOD_MODES: lod_modes <= cfg_data[49:0];
        default:       planes[cfg_index] <= cfg_data;
      endcase
    end
  end

  logic [2:0][15:0] box_min, box_max;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      box_min[k] = s_tdata[16 + 16*k +: 16];
      box_max[k] = s_tdata[64 + 16*k +: 16];
    end
  end

  logic                        cv [PLANE_COUNT+1];
  logic                        cr [PLANE_COUNT+1];
  ctl_t                        cctl [PLANE_COUNT+1];
  logic [2:0][COORD_WIDTH-1:0] clo [PLANE_COUNT+1];
  logic [2:0][COORD_WIDTH-1:0] chi [PLANE_COUNT+1];

  fcl_front #(.CW(COORD_WIDTH)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .tag            (s_tdata[15:0]),
    .box_min        (box_min),
    .box_max        (box_max),
    .far_limit      (s_tdata[127:112]),
    .near_limit     (s_tdata[143:128]),
    .always_visible (s_tuser),
    .cam            (cam),
    .lod_modes      (lod_modes),
    .out_valid      (cv[0]),
    .out_ready      (cr[0]),
    .ctl            (cctl[0]),
    .lo             (clo[0]),
    .hi             (chi[0])
  );

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
    logic [63:0] cell_plane;

    if (i < PLANE_REGS) begin : g_reg
      assign cell_plane = planes[i];
    end else begin : g_zero
      assign cell_plane = '0;
    end

    fcl_plane_cell #(.CW(COORD_WIDTH)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_ctl    (cctl[i]),
      .in_lo     (clo[i]),
      .in_hi     (chi[i]),
      .plane     (cell_plane),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_ctl   (cctl[i+1]),
      .out_lo    (clo[i+1]),
      .out_hi    (chi[i+1])
    );
  end

  ctl_t  fin;
  cull_e code;
  logic  en_o;

  assign fin  = cctl[PLANE_COUNT];
  assign en_o = !m_tvalid || m_tready;
  assign cr[PLANE_COUNT] = en_o;

  always_comb begin
    priority if (fin.dist_cull)                       code = CULL_DISTANCE;
    else if (fin.check_frustum && !fin.in_frustum)    code = CULL_FRUSTUM;
    else                                              code = CULL_VISIBLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_o) begin
      m_tvalid <= cv[PLANE_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      m_tdata <= {4'b0000, fin.lod, code, fin.tag};
    end
  end

endmodule

// ===== hw/rtl/fcl_checker.sv =====
`timescale 1ns / 1ps

module fcl_checker import fcl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[17:16] == CULL_VISIBLE || m_tdata[17:16] == CULL_DISTANCE ||
                  m_tdata[17:16] == CULL_FRUSTUM) && m_tdata[23:20] == 4'b0000)
    else $error("bad cull code or fill bits");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

endmodule

bind frustum_distance_cull_lod fcl_checker u_fcl_checker (.*);
